[hdl/rcfh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfh_pkg: shared types and constants of the ray/circle first hit block
// Register indexes and command codes used by the top level and the sequencer.
// ----------------------------------------------------------------------------
package rcfh_pkg;
  localparam logic [2:0] REG_DIR_COS      = 3'd0;
  localparam logic [2:0] REG_DIR_SIN      = 3'd1;
  localparam logic [2:0] REG_VEL_X        = 3'd2;
  localparam logic [2:0] REG_VEL_Y        = 3'd3;
  localparam logic [2:0] REG_RADIUS_SQ    = 3'd4;
  localparam logic [2:0] REG_MAX_LIFETIME = 3'd5;
  localparam logic [2:0] REG_ACTIVE_COUNT = 3'd6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // divider request/response between the sequencer and the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quo;
  } div_rsp_t;
endpackage

[hdl/ray_circle_first_hit_time.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_circle_first_hit_time: first obstacle hit time of a straight ray
// Loads circle centres into a table and, per query, walks the active
// entries with one shared multiplier, a square root unit and a divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | cmd, entry_index, coord_x/y
//  out     | output    | out_valid/out_stall| lifetime, started_inside
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A load item keeps in_stall high for one cycle after it is taken. A query
// keeps it high while it walks the N active entries: an entry that misses
// ends at the check, a hit runs the square root and then up to two
// 64-step divisions, and a start inside ends the walk early.
// Per entry, up to 7 multiplies run on the shared 36x33 multiplier.
// Reset clears control state and the configuration registers; the table holds garbage until written.
// in_stall is high while an item is at work, including while a finished
// result waits for the output register; once the result sits in the output
// register the next item is taken, and the result is held until out_stall
// is low.
module ray_circle_first_hit_time #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [6:0]  in_entry_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_lifetime,
  output logic        out_started_inside,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_M1    = 5'd2;   // dx*c
  localparam logic [4:0] S_M2    = 5'd3;   // dy*s
  localparam logic [4:0] S_M3    = 5'd4;   // inner*c
  localparam logic [4:0] S_M4    = 5'd5;   // inner*s
  localparam logic [4:0] S_M5    = 5'd6;   // ex*ex
  localparam logic [4:0] S_M6    = 5'd7;   // ey*ey
  localparam logic [4:0] S_CHK   = 5'd8;
  localparam logic [4:0] S_SQW   = 5'd9;
  localparam logic [4:0] S_M7    = 5'd10;  // l*u
  localparam logic [4:0] S_NUM   = 5'd11;
  localparam logic [4:0] S_D0    = 5'd12;
  localparam logic [4:0] S_D0W   = 5'd13;
  localparam logic [4:0] S_D1    = 5'd14;
  localparam logic [4:0] S_D1W   = 5'd15;
  localparam logic [4:0] S_NEXT  = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;
  localparam logic [4:0] S_LOAD  = 5'd18;

  // configuration
  logic signed [17:0] cos_r, sin_r;
  logic signed [31:0] vx_r, vy_r;
  logic [63:0] rsq_r;
  logic [31:0] maxl_r;
  logic [7:0]  act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r  <= 18'sd65536;
      sin_r  <= 18'sd0;
      vx_r   <= 32'sd0;
      vy_r   <= 32'sd0;
      rsq_r  <= 64'd0;
      maxl_r <= 32'hFFFF_FFFF;
      act_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        rcfh_pkg::REG_DIR_COS:      cos_r  <= cfg_data[17:0];
        rcfh_pkg::REG_DIR_SIN:      sin_r  <= cfg_data[17:0];
        rcfh_pkg::REG_VEL_X:        vx_r   <= cfg_data[31:0];
        rcfh_pkg::REG_VEL_Y:        vy_r   <= cfg_data[31:0];
        rcfh_pkg::REG_RADIUS_SQ:    rsq_r  <= cfg_data;
        rcfh_pkg::REG_MAX_LIFETIME: maxl_r <= cfg_data[31:0];
        rcfh_pkg::REG_ACTIVE_COUNT: act_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // obstacle table, x in the high half
  logic [63:0] tbl [TABLE_DEPTH];
  logic [63:0] rd_r;
  logic        wr_en;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) tbl[AW'(in_entry_index)] <= {in_coord_x, in_coord_y};
    rd_r <= tbl[rd_addr];
  end

  // state registers
  logic [4:0]  st_r, st_nxt;
  logic [CW-1:0] k_r, k_nxt, n_r, n_nxt;
  logic signed [31:0] x0_r, x0_nxt, y0_r, y0_nxt;
  logic signed [33:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [35:0] inner_r, inner_nxt;
  logic signed [63:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [64:0] a_r, a_nxt;
  logic signed [63:0] lu_r, lu_nxt;
  logic signed [63:0] base_r, base_nxt;
  logic signed [63:0] n0_r, n0_nxt, n1_r, n1_nxt;
  logic [31:0] life_r, life_nxt;
  logic        far_r, far_nxt;
  logic        ov_r, ov_nxt;
  logic        ins_r, ins_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] olife_r, olife_nxt;
  logic        oins_r, oins_nxt;

  // shared signed multiplier: 36 x 33 operands cover every product used
  logic signed [35:0] ma;
  logic signed [32:0] mb;
  logic signed [68:0] mp;
  assign mp = ma * mb;

  // rounding of a product at 2^-56 down to 2^-40, ties up
  function automatic logic signed [63:0] rnd16(input logic signed [68:0] v);
    logic signed [68:0] w;
    w = v + 69'sd32768;
    return 64'($signed(w[68:16]));
  endfunction

  rcfh_pkg::div_req_t dreq;
  rcfh_pkg::div_rsp_t drsp;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;

  rcfh_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  rcfh_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .x(rsq_r - a_r[63:0]),
    .done(sq_done), .root(sq_root));

  logic signed [31:0] vsel;
  logic [31:0] vmag;
  logic signed [63:0] nsel;
  logic [63:0] nmag;
  logic [32:0] tq;
  logic        t_sat;
  logic signed [63:0] tbx, tby;
  logic signed [1:0] sg0, sg1, sgv;
  logic [64:0] asum;
  logic        accepted;
  logic        out_free;

  assign tbx = 64'($signed(rd_r[63:32]));
  assign tby = 64'($signed(rd_r[31:0]));
  assign vsel = (vx_r != 32'sd0) ? vx_r : vy_r;
  assign vmag = vsel[31] ? 32'(-vsel) : vsel;
  assign sgv  = vsel[31] ? -2'sd1 : 2'sd1;
  assign sg0  = (n0_r == 64'sd0) ? 2'sd0 : (n0_r[63] ? -2'sd1 : 2'sd1);
  assign sg1  = (n1_r == 64'sd0) ? 2'sd0 : (n1_r[63] ? -2'sd1 : 2'sd1);
  assign out_free = !ovalid_r || !out_stall;
  assign in_stall = (st_r != S_IDLE);
  assign accepted = in_valid && !in_stall;
  assign wr_en = accepted && (in_cmd == rcfh_pkg::CMD_LOAD) &&
                 ({25'd0, in_entry_index} < 32'(TABLE_DEPTH));
  assign rd_addr = k_r[AW-1:0];
  assign asum = {1'b0, a_r[63:0]};

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      S_M1: begin ma = 36'(dx_r); mb = 33'(cos_r); end
      S_M2: begin ma = 36'(dy_r); mb = 33'(sin_r); end
      S_M3: begin ma = inner_r; mb = 33'(cos_r); end
      S_M4: begin ma = inner_r; mb = 33'(sin_r); end
      S_M5: begin ma = 36'(ex_r); mb = 33'(ex_r); end
      S_M6: begin ma = 36'(ey_r); mb = 33'(ey_r); end
      S_M7: begin
        ma = $signed({4'd0, sq_root});
        mb = (vx_r != 32'sd0) ? 33'(cos_r) : 33'(sin_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    nsel = (st_r == S_D0) ? n0_r : n1_r;
    nmag = nsel[63] ? 64'(-nsel) : nsel;
    t_sat = nmag >= {32'd0, vmag};
    tq = drsp.quo;
  end

  always_comb begin
    st_nxt = st_r; k_nxt = k_r; n_nxt = n_r;
    x0_nxt = x0_r; y0_nxt = y0_r; dx_nxt = dx_r; dy_nxt = dy_r;
    acc_nxt = acc_r; inner_nxt = inner_r; ex_nxt = ex_r; ey_nxt = ey_r;
    a_nxt = a_r; lu_nxt = lu_r; base_nxt = base_r; n0_nxt = n0_r; n1_nxt = n1_r;
    life_nxt = life_r; far_nxt = far_r; ov_nxt = ov_r; ins_nxt = ins_r;
    ovalid_nxt = ovalid_r; olife_nxt = olife_r; oins_nxt = oins_r;
    dreq.start = 1'b0;
    dreq.num = {nmag[31:0], 32'd0};
    dreq.den = vmag;
    sq_start = 1'b0;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (accepted) begin
          x0_nxt = in_coord_x;
          y0_nxt = in_coord_y;
          life_nxt = maxl_r;
          ins_nxt = 1'b0;
          k_nxt = '0;
          // clamp the walk at the table depth
          n_nxt = ({24'd0, act_r} > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(act_r);
          st_nxt = (in_cmd == rcfh_pkg::CMD_LOAD) ? S_LOAD : S_NEXT;
        end
      end
      S_LOAD: st_nxt = S_IDLE;
      S_NEXT: begin
        if (k_r == n_r) st_nxt = S_OUT;
        else st_nxt = S_RD;
      end
      S_RD: begin
        dx_nxt = 34'(tbx) - 34'(x0_r);
        dy_nxt = 34'(tby) - 34'(y0_r);
        st_nxt = S_M1;
      end
      S_M1: begin acc_nxt = 64'(mp); st_nxt = S_M2; end
      S_M2: begin
        inner_nxt = 36'(rnd16(69'(acc_r) + mp));
        st_nxt = S_M3;
      end
      S_M3: begin
        ex_nxt = 64'(x0_r) + rnd16(mp) - tbx;   // px - ix
        st_nxt = S_M4;
      end
      S_M4: begin
        ey_nxt = 64'(y0_r) + rnd16(mp) - tby;
        st_nxt = S_M5;
      end
      S_M5: begin
        far_nxt = (ex_r >= 64'sh1_0000_0000) || (ex_r <= -64'sh1_0000_0000) ||
                  (ey_r >= 64'sh1_0000_0000) || (ey_r <= -64'sh1_0000_0000);
        a_nxt = {1'b0, 64'(mp)};
        st_nxt = S_M6;
      end
      S_M6: begin
        a_nxt = asum + {1'b0, 64'(mp)};
        st_nxt = S_CHK;
      end
      S_CHK: begin
        // drop far projections, overflow, misses and zero velocity
        if (far_r || a_r[64] || a_r[63:0] > rsq_r || vsel == 32'sd0) begin
          k_nxt = k_r + CW'(1);
          st_nxt = S_NEXT;
        end else begin
          sq_start = 1'b1;
          st_nxt = S_SQW;
        end
      end
      S_SQW: if (sq_done) st_nxt = S_M7;
      S_M7: begin
        lu_nxt = rnd16(mp);
        base_nxt = (vx_r != 32'sd0) ? (64'(x0_r) - (ex_r + tbx)) :
                                      (64'(y0_r) - (ey_r + tby));
        st_nxt = S_NUM;
      end
      S_NUM: begin
        n0_nxt = base_r + lu_r;
        n1_nxt = base_r - lu_r;
        st_nxt = S_D0;
      end
      S_D0: begin
        if (sg0 * sg1 < 0) begin
          ins_nxt = 1'b1;
          st_nxt = S_OUT;
        end else if (sg0 * sgv > 0) begin
          if (t_sat) st_nxt = S_D1;
          else begin dreq.start = 1'b1; st_nxt = S_D0W; end
        end else st_nxt = S_D1;
      end
      S_D0W: if (drsp.done) begin
        if (tq[31:0] < life_r && !tq[32]) life_nxt = tq[31:0];
        st_nxt = S_D1;
      end
      S_D1: begin
        if (sg1 * sgv > 0 && !t_sat) begin
          dreq.start = 1'b1;
          st_nxt = S_D1W;
        end else begin
          k_nxt = k_r + CW'(1);
          st_nxt = S_NEXT;
        end
      end
      S_D1W: if (drsp.done) begin
        if (tq[31:0] < life_r && !tq[32]) life_nxt = tq[31:0];
        k_nxt = k_r + CW'(1);
        st_nxt = S_NEXT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          ovalid_nxt = 1'b1;
          olife_nxt = ins_r ? 32'd0 : life_r;
          oins_nxt = ins_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    ov_nxt = ovalid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
      ov_r <= 1'b0;
      k_r <= '0;
      n_r <= '0;
    end else begin
      st_r <= st_nxt;
      ovalid_r <= ovalid_nxt;
      ov_r <= ov_nxt;
      k_r <= k_nxt;
      n_r <= n_nxt;
    end
    x0_r <= x0_nxt; y0_r <= y0_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt;
    acc_r <= acc_nxt; inner_r <= inner_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    a_r <= a_nxt; lu_r <= lu_nxt; base_r <= base_nxt; n0_r <= n0_nxt; n1_r <= n1_nxt;
    life_r <= life_nxt; far_r <= far_nxt; ins_r <= ins_nxt;
    olife_r <= olife_nxt; oins_r <= oins_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_lifetime = olife_r;
  assign out_started_inside = oins_r;

  a_ov_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r == ovalid_r) else $error("output valid copies differ");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= n_r) else $error("entry walk past count");
  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_started_inside |-> out_lifetime == 32'd0)
    else $error("inside with nonzero lifetime");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> in_stall) else $error("input taken while busy");
endmodule

[hdl/rcfh_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfh_div: restoring divider, one quotient bit per cycle
// Computes (num) / den for num < den * 2^33, quotient of 33 bits.
// ----------------------------------------------------------------------------
module rcfh_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rcfh_pkg::div_req_t req,
  output rcfh_pkg::div_rsp_t rsp
);
  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] num_r, num_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[63]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = 64'd0;
      num_nxt  = req.num;
      den_nxt  = req.den;
      quo_nxt  = 33'd0;
    end else if (busy_r) begin
      // shift one numerator bit in, subtract when it fits
      num_nxt = {num_r[62:0], 1'b0};
      if (trial >= {33'd0, den_r}) begin
        rem_nxt = 64'(trial - {33'd0, den_r});
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start && cnt_r != 6'd63 |=> busy_r)
    else $error("divider stopped early");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
endmodule

[hdl/rcfh_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfh_sqrt: bit-pair integer square root of a 64-bit value
// One result bit per cycle, for a 32-bit root.
// ----------------------------------------------------------------------------
module rcfh_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] x_r, x_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [35:0] trial;
  logic [35:0] tv;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    trial    = {rem_r, x_r[63:62]};
    tv       = {2'b00, q_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      x_nxt    = x;
      rem_nxt  = 34'd0;
      q_nxt    = 32'd0;
    end else if (busy_r) begin
      x_nxt = {x_r[61:0], 2'b00};
      if (trial >= tv) begin
        rem_nxt = 34'(trial - tv);
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[33:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign root = q_r;
endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the ray/circle first hit time block
// Loads obstacle centres, runs particle queries under several register
// settings and random stalls on both channels, and checks every lifetime
// against an in-bench fixed point predictor.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int DEPTH     = 128;
  localparam int LIMIT_CYC = 8000000;

  typedef struct {
    logic        cmd;
    logic [6:0]  idx;
    logic [31:0] cx;
    logic [31:0] cy;
  } item_t;

  typedef struct {
    logic [31:0] life;
    logic        ins;
  } hit_t;

  logic clk, rst_n;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  logic [6:0] in_entry_index = 7'd0;
  logic signed [31:0] in_coord_x = 32'sd0;
  logic signed [31:0] in_coord_y = 32'sd0;
  logic out_valid, out_started_inside;
  logic out_stall = 1'b0;
  logic [31:0] out_lifetime;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  ray_circle_first_hit_time u_dut (.*);

  // predictor copy of the table and registers
  logic [63:0] centre_tbl [DEPTH];
  logic signed [17:0] m_cos, m_sin;
  logic signed [31:0] m_vx, m_vy;
  logic [63:0] m_rsq;
  logic [31:0] m_maxlife;
  logic [7:0]  m_count;

  item_t pending_items[$];
  hit_t  expected_hits[$];
  int    errors = 0;
  int    send_idle_pct = 0, recv_idle_pct = 0;
  bit    hold_send = 0;
  longint cycles = 0;

  // stall as seen at the last rising edge, so the driver knows acceptance
  logic in_stall_q;
  always @(posedge clk) in_stall_q <= in_stall;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint rshift_rnd(longint v, int n);
    longint w;
    w = v + (longint'(1) << (n - 1));
    return w >>> n;  // arithmetic shift is floor
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic int sign64(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint unsigned cross_time(longint num, longint v);
    longint unsigned n, d;
    n = abs64(num);
    d = abs64(v);
    if (n >= d) return 64'h1_0000_0000;
    return (n << 32) / d;
  endfunction

  // walk the active entries and return the first hit time of one query
  function automatic hit_t first_hit(logic [31:0] sx, logic [31:0] sy);
    hit_t h;
    longint x0, y0, c, s, vx, vy, ix, iy, inner, px, py, ex, ey;
    longint v, base, lu, n0, n1;
    longint unsigned life, a, qx, qy, l, t;
    int n, s0, s1;
    x0 = longint'($signed(sx));
    y0 = longint'($signed(sy));
    c = m_cos; s = m_sin; vx = m_vx; vy = m_vy;
    life = m_maxlife;
    n = (m_count > DEPTH) ? DEPTH : m_count;
    h.ins = 0;
    for (int k = 0; k < n; k++) begin
      ix = longint'($signed(centre_tbl[k][63:32]));
      iy = longint'($signed(centre_tbl[k][31:0]));
      inner = rshift_rnd((ix - x0) * c + (iy - y0) * s, 16);
      px = x0 + rshift_rnd(inner * c, 16);
      py = y0 + rshift_rnd(inner * s, 16);
      ex = px - ix;
      ey = py - iy;
      if (ex >= 64'sh1_0000_0000 || ex <= -64'sh1_0000_0000 ||
          ey >= 64'sh1_0000_0000 || ey <= -64'sh1_0000_0000) continue;
      qx = abs64(ex) * abs64(ex);
      qy = abs64(ey) * abs64(ey);
      a = qx + qy;
      if (a < qx || a > m_rsq) continue;
      l = root64(m_rsq - a);
      if (vx != 0) begin
        v = vx; base = x0 - px; lu = rshift_rnd(longint'(l) * c, 16);
      end else begin
        v = vy; base = y0 - py; lu = rshift_rnd(longint'(l) * s, 16);
      end
      if (v == 0) continue;
      n0 = base + lu;
      n1 = base - lu;
      s0 = sign64(n0) * sign64(v);
      s1 = sign64(n1) * sign64(v);
      if (s0 * s1 < 0) begin
        h.life = 0;
        h.ins = 1;
        return h;
      end
      if (s0 > 0) begin
        t = cross_time(n0, v);
        if (t < life) life = t;
      end
      if (s1 > 0) begin
        t = cross_time(n1, v);
        if (t < life) life = t;
      end
    end
    h.life = life[31:0];
    return h;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // one register write, mirrored into the predictor
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      rcfh_pkg::REG_DIR_COS:      m_cos = val[17:0];
      rcfh_pkg::REG_DIR_SIN:      m_sin = val[17:0];
      rcfh_pkg::REG_VEL_X:        m_vx = val[31:0];
      rcfh_pkg::REG_VEL_Y:        m_vy = val[31:0];
      rcfh_pkg::REG_RADIUS_SQ:    m_rsq = val;
      rcfh_pkg::REG_MAX_LIFETIME: m_maxlife = val[31:0];
      rcfh_pkg::REG_ACTIVE_COUNT: m_count = val[7:0];
      default: ;
    endcase
  endtask

  // Driver: hold the payload while stalled, advance on acceptance.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_valid && in_stall_q)) begin
        if (pending_items.size() != 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          item_t it;
          it = pending_items.pop_front();
          in_valid <= 1;
          in_cmd <= it.cmd;
          in_entry_index <= it.idx;
          in_coord_x <= it.cx;
          in_coord_y <= it.cy;
          if (it.cmd == rcfh_pkg::CMD_QUERY) expected_hits.push_back(first_hit(it.cx, it.cy));
          else centre_tbl[it.idx] = {it.cx, it.cy};
        end else begin
          in_valid <= 0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", out_lifetime, 32'd0);
      end else begin
        hit_t e;
        e = expected_hits.pop_front();
        if (out_lifetime !== e.life) report_mismatch("lifetime", out_lifetime, e.life);
        if (out_started_inside !== e.ins)
          report_mismatch("started_inside", {31'd0, out_started_inside}, {31'd0, e.ins});
      end
    end
  end

  initial begin
    wait (cycles >= LIMIT_CYC);
    $display("Simulation FAILED");
    $finish;
  end

  // wait until the driver has sent everything and every result has come
  task automatic drain();
    while (pending_items.size() != 0 || in_valid) @(negedge clk);
    while (expected_hits.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic void push_item(logic cmd, logic [6:0] idx, logic [31:0] x, logic [31:0] y);
    item_t it;
    it.cmd = cmd; it.idx = idx; it.cx = x; it.cy = y;
    pending_items.push_back(it);
  endfunction

  // random coordinate: mostly near the origin so hits happen, sometimes full range
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(2000000)) - 1000000;
  endfunction

  task automatic load_table(int n);
    for (int k = 0; k < n; k++)
      push_item(rcfh_pkg::CMD_LOAD, 7'(k), rand_coord(), rand_coord());
  endtask

  // pick a random direction, velocity, radius, lifetime limit and active count; keep active entries written
  task automatic random_setting(int n);
    int d;
    d = $urandom_range(5);
    case (d)
      0: begin
        write_reg(rcfh_pkg::REG_DIR_COS, 64'h10000); write_reg(rcfh_pkg::REG_DIR_SIN, 0);
      end
      1: begin
        write_reg(rcfh_pkg::REG_DIR_COS, 64'h30000); write_reg(rcfh_pkg::REG_DIR_SIN, 0);
      end
      2: begin
        write_reg(rcfh_pkg::REG_DIR_COS, 0); write_reg(rcfh_pkg::REG_DIR_SIN, 64'h10000);
      end
      3: begin
        write_reg(rcfh_pkg::REG_DIR_COS, 0); write_reg(rcfh_pkg::REG_DIR_SIN, 64'h30000);
      end
      default: begin
        write_reg(rcfh_pkg::REG_DIR_COS, 46341);
        write_reg(rcfh_pkg::REG_DIR_SIN, 64'h3FFFF & -46341);
      end
    endcase
    write_reg(rcfh_pkg::REG_VEL_X, ($urandom_range(3) == 0) ? 0 : $urandom);
    write_reg(rcfh_pkg::REG_VEL_Y, $urandom);
    write_reg(rcfh_pkg::REG_RADIUS_SQ, {$urandom_range(1 << 9), $urandom});
    write_reg(rcfh_pkg::REG_MAX_LIFETIME, ($urandom_range(1)) ? 32'hFFFF_FFFF : $urandom);
    write_reg(rcfh_pkg::REG_ACTIVE_COUNT, n);
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    m_cos = 18'sh10000; m_sin = 0; m_vx = 0; m_vy = 0; m_rsq = 0;
    m_maxlife = 32'hFFFF_FFFF; m_count = 0;
    repeat (5) @(negedge clk);
    rst_n = 1;

    // directed: empty query, extremes of coordinates, zero velocity
    push_item(rcfh_pkg::CMD_QUERY, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    for (int k = 0; k < 8; k++) push_item(rcfh_pkg::CMD_LOAD, 7'(k), 0, 0);
    push_item(rcfh_pkg::CMD_LOAD, 7'h7F, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    write_reg(rcfh_pkg::REG_ACTIVE_COUNT, 8);
    write_reg(rcfh_pkg::REG_RADIUS_SQ, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(rcfh_pkg::CMD_QUERY, 0, 0, 0);             // zero velocity: all miss
    drain();
    write_reg(rcfh_pkg::REG_VEL_X, 32'h7FFF_FFFF);
    push_item(rcfh_pkg::CMD_QUERY, 0, 0, 0);             // start inside
    push_item(rcfh_pkg::CMD_QUERY, 0, 32'h8000_0000, 0); // far behind, inside the large radius
    push_item(rcfh_pkg::CMD_QUERY, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    write_reg(rcfh_pkg::REG_VEL_X, 0);
    write_reg(rcfh_pkg::REG_VEL_Y, 32'h8000_0000);
    write_reg(rcfh_pkg::REG_DIR_COS, 0);
    write_reg(rcfh_pkg::REG_DIR_SIN, 64'h30000);
    write_reg(rcfh_pkg::REG_MAX_LIFETIME, 0);
    push_item(rcfh_pkg::CMD_QUERY, 0, 0, 32'h7FFF_FFFF);
    push_item(rcfh_pkg::CMD_QUERY, 0, 5, 5);
    drain();
    write_reg(rcfh_pkg::REG_ACTIVE_COUNT, 8'hFF);        // beyond depth; load all slots first
    write_reg(rcfh_pkg::REG_RADIUS_SQ, 0);
    write_reg(rcfh_pkg::REG_MAX_LIFETIME, 32'hFFFF_FFFF);
    load_table(DEPTH);
    push_item(rcfh_pkg::CMD_QUERY, 0, 1, 1);
    drain();

    // random phases across the idling schedule
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : ((ph == 1) ? 55 : 0);
      recv_idle_pct = (ph == 0) ? 55 : ((ph == 1) ? 22 : 0);
      for (int r = 0; r < 5; r++) begin
        int n;
        n = $urandom_range(1, 6);
        random_setting(n);
        load_table(n);
        for (int q = 0; q < 6; q++) begin
          if ($urandom_range(4) == 0) push_item(rcfh_pkg::CMD_LOAD, 7'($urandom_range(n - 1)),
                                                rand_coord(), rand_coord());
          push_item(rcfh_pkg::CMD_QUERY, 7'($urandom), rand_coord(), rand_coord());
        end
        if (r == 2) begin
          // let some items go, then hold off the sender until every result is in
          while (pending_items.size() > 4) @(negedge clk);
          hold_send = 1;
          while (expected_hits.size() != 0) @(negedge clk);
          hold_send = 0;
        end
        drain();
      end
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
